>>> hdl/group_membership_table_core_assert.svh
// assertion macros for the group membership table
// no dependencies; used at the end of group_membership_table_core
`ifndef GROUP_MEMBERSHIP_TABLE_CORE_ASSERT_SVH
`define GROUP_MEMBERSHIP_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gmt_pkg.sv
// shared types and defaults for the group membership table
// no dependencies
package gmt_pkg;

  // default geometry
  localparam int NUM_GROUPS_DEF      = 8;
  localparam int SLOTS_PER_GROUP_DEF = 8;
  localparam int NODE_W              = 8;
  localparam int GROUP_W             = 8;

  // request modes
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // insert status codes
  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LIST
  } state_t;

endpackage

>>> hdl/group_membership_table_core.sv
// group membership table: one row-wide memory plus a small sequencer
// depends on gmt_pkg and group_membership_table_core_assert.svh
//
// Usage: drive in_mode, in_node_id and in_group_id with start high; the item
// is taken at the clock edge where start is high and busy is low. Each group
// owns one memory row holding all of its slots, so every request is a single
// row read, a check of all slots at once, and at most one row write-back.
// Results appear on the out_ ports for one cycle each, marked by out_valid,
// and out_last flags the final result of an item. The receiver cannot stall.
// Insert, lookup, clear and an empty list evaluate the registered row in
// S_EVAL and register their single result; busy drops as that result
// appears. A list with m members emits one member per cycle from S_LIST,
// after S_EVAL, and busy drops as its last member appears.
// The memory read is synchronous, so the row is registered before S_EVAL.
// Reset (rst_n low, synchronous) clears the per-row valid bits, so every row
// reads as empty at once; clear does the same. No clearing pass.
module group_membership_table_core #(
  parameter int NUM_GROUPS      = gmt_pkg::NUM_GROUPS_DEF,
  parameter int SLOTS_PER_GROUP = gmt_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [gmt_pkg::NODE_W-1:0]   in_node_id,
  input  logic [gmt_pkg::GROUP_W-1:0]  in_group_id,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic                         out_present,
  output logic                         out_can_add,
  output logic [gmt_pkg::NODE_W-1:0]   out_member_node,
  output logic                         out_member_valid,
  output logic                         out_last
);

  localparam int NW     = gmt_pkg::NODE_W;
  localparam int GW     = gmt_pkg::GROUP_W;
  localparam int ROW_W  = SLOTS_PER_GROUP * NW;
  localparam int ROW_AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // sequencer and item registers
  gmt_pkg::state_t              state_r, state_nxt;
  gmt_pkg::mode_t               mode_r;
  logic [NW-1:0]                node_r;
  logic                         grp_zero_r;
  logic                         grp_ok_r;
  logic [ROW_AW-1:0]            row_addr_r;

  // memory and row valid bits
  logic [ROW_W-1:0]             mem [NUM_GROUPS];
  logic [ROW_W-1:0]             rd_data_r;
  logic [NUM_GROUPS-1:0]        row_vld_r, row_vld_nxt;
  logic                         mem_we;
  logic [ROW_W-1:0]             wr_data;

  // list walk
  logic [SLOTS_PER_GROUP-1:0]   pend_r, pend_nxt;
  logic [ROW_W-1:0]             list_row_r, list_row_nxt;

  // result registers
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic                         out_present_r, out_present_nxt;
  logic                         out_can_add_r, out_can_add_nxt;
  logic [NW-1:0]                out_member_r, out_member_nxt;
  logic                         out_mvalid_r, out_mvalid_nxt;
  logic                         out_last_r, out_last_nxt;

  // decoded control
  logic                         accept;
  logic                         do_eval;
  logic                         do_list;

  // row check
  logic [ROW_W-1:0]             row_eff;
  logic [SLOTS_PER_GROUP-1:0]   slot_free, slot_hit, slot_stop, stop_first;
  logic [SLOTS_PER_GROUP-1:0]   slot_other;
  logic [SLOTS_PER_GROUP-1:0]   list_first;
  logic [NW-1:0]                list_member;
  logic [GW-1:0]                grp_m1;

  assign accept = start && !busy;
  assign grp_m1 = in_group_id - GW'(1);

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= gmt_pkg::mode_t'(in_mode);
      node_r     <= in_node_id;
      grp_zero_r <= (in_group_id == '0);
      grp_ok_r   <= (in_group_id != '0) && (in_group_id <= GW'(NUM_GROUPS));
      row_addr_r <= grp_m1[ROW_AW-1:0];
    end
  end

  // row memory: one read port at accept, one write port at evaluation
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[grp_m1[ROW_AW-1:0]];
    end
    if (mem_we) begin
      mem[row_addr_r] <= wr_data;
    end
  end

  // effective row: an unwritten row reads as empty
  assign row_eff = (grp_ok_r && row_vld_r[row_addr_r]) ? rd_data_r : '0;

  // per-slot flags, all slots in parallel
  always_comb begin
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      slot_free[s]  = (row_eff[s*NW +: NW] == '0);
      slot_hit[s]   = (row_eff[s*NW +: NW] == node_r);
      slot_other[s] = !slot_free[s] && !slot_hit[s];
    end
    slot_stop  = slot_free | slot_hit;
    stop_first = slot_stop & (~slot_stop + SLOTS_PER_GROUP'(1));
  end

  // insert write-back row: node goes into the first stop slot if it is free
  always_comb begin
    wr_data = row_eff;
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      if (stop_first[s] && slot_free[s]) begin
        wr_data[s*NW +: NW] = node_r;
      end
    end
  end

  // list walk: lowest pending slot
  always_comb begin
    list_first  = pend_r & (~pend_r + SLOTS_PER_GROUP'(1));
    list_member = '0;
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      if (list_first[s]) begin
        list_member = list_row_r[s*NW +: NW];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gmt_pkg::S_IDLE: begin
        if (start) state_nxt = gmt_pkg::S_EVAL;
      end
      gmt_pkg::S_EVAL: begin
        if (mode_r == gmt_pkg::MODE_LIST && grp_ok_r && (slot_other != '0)) begin
          state_nxt = gmt_pkg::S_LIST;
        end else begin
          state_nxt = gmt_pkg::S_IDLE;
        end
      end
      gmt_pkg::S_LIST: begin
        if ((pend_r & ~list_first) == '0) state_nxt = gmt_pkg::S_IDLE;
      end
      default: state_nxt = gmt_pkg::S_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    busy    = 1'b1;
    do_eval = 1'b0;
    do_list = 1'b0;
    unique case (state_r)
      gmt_pkg::S_IDLE: busy    = 1'b0;
      gmt_pkg::S_EVAL: do_eval = 1'b1;
      gmt_pkg::S_LIST: do_list = 1'b1;
      default:         busy    = 1'b1;
    endcase
  end

  // evaluation and result formation
  always_comb begin
    mem_we          = 1'b0;
    row_vld_nxt     = row_vld_r;
    pend_nxt        = pend_r;
    list_row_nxt    = list_row_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = 2'(gmt_pkg::ST_ADDED);
    out_present_nxt = 1'b0;
    out_can_add_nxt = 1'b0;
    out_member_nxt  = '0;
    out_mvalid_nxt  = 1'b0;
    out_last_nxt    = 1'b0;
    if (do_eval) begin
      unique case (mode_r)
        gmt_pkg::MODE_INSERT: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (node_r == '0 || !grp_ok_r) begin
            out_status_nxt = 2'(gmt_pkg::ST_IGNORED);
          end else if (stop_first == '0) begin
            out_status_nxt = 2'(gmt_pkg::ST_FULL);
          end else if ((stop_first & slot_free) != '0) begin
            out_status_nxt           = 2'(gmt_pkg::ST_ADDED);
            mem_we                   = 1'b1;
            row_vld_nxt[row_addr_r]  = 1'b1;
          end else begin
            out_status_nxt = 2'(gmt_pkg::ST_PRESENT);
          end
        end
        gmt_pkg::MODE_LOOKUP: begin
          out_valid_nxt   = 1'b1;
          out_last_nxt    = 1'b1;
          out_present_nxt = grp_ok_r && (node_r != '0) && (slot_hit != '0);
          out_can_add_nxt = grp_zero_r || (grp_ok_r && (slot_stop != '0));
        end
        gmt_pkg::MODE_LIST: begin
          if (grp_ok_r && (slot_other != '0)) begin
            pend_nxt     = slot_other;
            list_row_nxt = row_eff;
          end else begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end
        end
        gmt_pkg::MODE_CLEAR: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          row_vld_nxt   = '0;
        end
      endcase
    end else if (do_list) begin
      out_valid_nxt  = 1'b1;
      out_member_nxt = list_member;
      out_mvalid_nxt = 1'b1;
      pend_nxt       = pend_r & ~list_first;
      out_last_nxt   = ((pend_r & ~list_first) == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmt_pkg::S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r        <= pend_nxt;
    list_row_r    <= list_row_nxt;
    out_status_r  <= out_status_nxt;
    out_present_r <= out_present_nxt;
    out_can_add_r <= out_can_add_nxt;
    out_member_r  <= out_member_nxt;
    out_mvalid_r  <= out_mvalid_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_present      = out_present_r;
  assign out_can_add      = out_can_add_r;
  assign out_member_node  = out_member_r;
  assign out_member_valid = out_mvalid_r;
  assign out_last         = out_last_r;

  // checks
`include "group_membership_table_core_assert.svh"

  `GMT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
  `GMT_ASSERT_NEXT(a_list_burst, out_valid && !out_last, out_valid, "list burst broke off")
  `GMT_ASSERT_NOW(a_midlist_busy, out_valid && !out_last, busy, "idle during list burst")
  `GMT_ASSERT_NOW(a_write_insert, mem_we, do_eval && mode_r == gmt_pkg::MODE_INSERT,
    "row write outside insert")

endmodule

>>> dv/tb_top.sv
// self-checking testbench for group_membership_table_core: directed rows, then random requests
// depends on gmt_pkg and the RTL of group_membership_table_core; reads no files
// a behavioral copy of the membership table predicts every result, compared in arrival order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gmt_pkg::*;

  localparam int NUM_GROUPS      = NUM_GROUPS_DEF;
  localparam int SLOTS_PER_GROUP = SLOTS_PER_GROUP_DEF;
  localparam int RANDOM_ITEMS    = 435;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_REPORTS     = 10;
  localparam bit TYPED           = 1'b1;
  localparam bit PREDICTED       = 1'b0;

  // one result as it appears on the out_ ports
  typedef struct packed {
    status_t              status;
    logic                 present;
    logic                 can_add;
    logic [NODE_W-1:0]    member_node;
    logic                 member_valid;
    logic                 last;
  } member_result_t;

  // directed row: request plus, where obvious, its single expected result
  typedef struct packed {
    mode_t                mode;
    logic [NODE_W-1:0]    node;
    logic [GROUP_W-1:0]   group;
    bit                   typed;
    status_t              w_status;
    bit                   w_present;
    bit                   w_can_add;
    bit                   w_member_valid;
    bit                   w_last;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_mode;
  logic [NODE_W-1:0]    in_node_id;
  logic [GROUP_W-1:0]   in_group_id;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic                 out_present;
  logic                 out_can_add;
  logic [NODE_W-1:0]    out_member_node;
  logic                 out_member_valid;
  logic                 out_last;

  // shadow copy of the table and the results still to arrive
  logic [NODE_W-1:0]    member_rows [NUM_GROUPS][SLOTS_PER_GROUP];
  member_result_t       step_results [SLOTS_PER_GROUP];
  int                   step_count;
  member_result_t       pending_results [$];
  int                   mismatch_count;

  directed_row_t directed_rows [26] = '{
    // empty table after reset
    '{MODE_LOOKUP,   8'd5, 8'd1,   TYPED,     ST_ADDED,   1'b0, 1'b1, 1'b0, 1'b1},
    '{MODE_LIST,     8'd0, 8'd1,   TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    // ignored inserts: node 0, group 0, group out of range
    '{MODE_INSERT,   8'd0, 8'd1,   TYPED,     ST_IGNORED, 1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_INSERT,   8'd5, 8'd0,   TYPED,     ST_IGNORED, 1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_INSERT,   8'd5, 8'd9,   TYPED,     ST_IGNORED, 1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_INSERT,   8'd5, 8'd255, TYPED,     ST_IGNORED, 1'b0, 1'b0, 1'b0, 1'b1},
    // add, then duplicate
    '{MODE_INSERT, 8'd255, 8'd1,   TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_INSERT, 8'd255, 8'd1,   TYPED,     ST_PRESENT, 1'b0, 1'b0, 1'b0, 1'b1},
    // fill the rest of group 1
    '{MODE_INSERT,   8'd2, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd3, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd4, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd5, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd6, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd7, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd1, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_INSERT,   8'd9, 8'd1,   TYPED,     ST_FULL,    1'b0, 1'b0, 1'b0, 1'b1},
    // lookups: member of full row, node 0 on full row, group 0, out of range
    '{MODE_LOOKUP,   8'd4, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_LOOKUP,   8'd0, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_LOOKUP,   8'd0, 8'd0,   TYPED,     ST_ADDED,   1'b0, 1'b1, 1'b0, 1'b1},
    '{MODE_LOOKUP,   8'd7, 8'd9,   TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    // lists: every slot, all but one, out of range
    '{MODE_LIST,     8'd0, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_LIST,   8'd255, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0},
    '{MODE_LIST,     8'd3, 8'd128, TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    // last group, then clear and look again
    '{MODE_INSERT, 8'd200, 8'd8,   TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_CLEAR,    8'd0, 8'd0,   TYPED,     ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b1},
    '{MODE_LOOKUP, 8'd255, 8'd1,   PREDICTED, ST_ADDED,   1'b0, 1'b0, 1'b0, 1'b0}
  };

  group_membership_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_node_id       (in_node_id),
    .in_group_id      (in_group_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_present      (out_present),
    .out_can_add      (out_can_add),
    .out_member_node  (out_member_node),
    .out_member_valid (out_member_valid),
    .out_last         (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // apply one request to the shadow table, leaving its results in step_results
  task automatic predict_request(input mode_t m, input logic [NODE_W-1:0] n,
                                 input logic [GROUP_W-1:0] g);
    bit             in_range;
    int             row;
    member_result_t r;
    logic           pres;
    logic           can;
    in_range = (g != '0) && (int'(g) <= NUM_GROUPS);
    row = in_range ? int'(g) - 1 : 0;
    r = '0;
    r.last = 1'b1;
    step_count = 0;
    case (m)
      MODE_INSERT: begin
        r.status = ST_IGNORED;
        if (n != '0 && in_range) begin
          r.status = ST_FULL;
          for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            if (member_rows[row][s] == '0) begin
              member_rows[row][s] = n;
              r.status = ST_ADDED;
              break;
            end
            if (member_rows[row][s] == n) begin
              r.status = ST_PRESENT;
              break;
            end
          end
        end
        step_results[0] = r;
        step_count = 1;
      end
      MODE_LOOKUP: begin
        pres = 1'b0;
        can = (g == '0);
        if (in_range) begin
          for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            if (n != '0 && member_rows[row][s] == n) pres = 1'b1;
            if (member_rows[row][s] == n || member_rows[row][s] == '0) can = 1'b1;
          end
        end
        r.present = pres;
        r.can_add = can;
        step_results[0] = r;
        step_count = 1;
      end
      MODE_LIST: begin
        // members in slot order, skipping free slots and the named node
        if (in_range) begin
          for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            if (member_rows[row][s] != '0 && member_rows[row][s] != n) begin
              step_results[step_count] = '0;
              step_results[step_count].member_node = member_rows[row][s];
              step_results[step_count].member_valid = 1'b1;
              step_count++;
            end
          end
        end
        if (step_count == 0) begin
          step_results[0] = r;
          step_count = 1;
        end else begin
          step_results[step_count-1].last = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int gi = 0; gi < NUM_GROUPS; gi++)
          for (int s = 0; s < SLOTS_PER_GROUP; s++)
            member_rows[gi][s] = '0;
        step_results[0] = r;
        step_count = 1;
      end
    endcase
  endtask

  // present one item after a random gap, then record its expected results once busy drops
  task automatic send_request(input mode_t m, input logic [NODE_W-1:0] n,
                              input logic [GROUP_W-1:0] g, input bit typed,
                              input member_result_t want);
    int gap;
    int r;
    r = $urandom_range(99, 0);
    if (r < 60)      gap = 0;
    else if (r < 90) gap = $urandom_range(3, 1);
    else             gap = $urandom_range(30, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= m;
    in_node_id  <= n;
    in_group_id <= g;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_request(m, n, g);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      for (int k = 0; k < step_count; k++) pending_results.push_back(step_results[k]);
    end
  endtask

  task automatic note_mismatch(input string what, input member_result_t want,
                               input member_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected status=%0d present=%0d can_add=%0d member=%0d mvalid=%0d last=%0d",
               want.status, want.present, want.can_add, want.member_node,
               want.member_valid, want.last);
      $display("  actual   status=%0d present=%0d can_add=%0d member=%0d mvalid=%0d last=%0d",
               got.status, got.present, got.can_add, got.member_node,
               got.member_valid, got.last);
    end
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    member_result_t got;
    member_result_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      got.status       = status_t'(out_status);
      got.present      = out_present;
      got.can_add      = out_can_add;
      got.member_node  = out_member_node;
      got.member_valid = out_member_valid;
      got.last         = out_last;
      if (pending_results.size() == 0) begin
        note_mismatch("result with no item outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (out_valid !== 1'b1 ||
            got.status !== want.status || got.present !== want.present ||
            got.can_add !== want.can_add || got.member_node !== want.member_node ||
            got.member_valid !== want.member_valid || got.last !== want.last)
          note_mismatch("result differs", want, got);
      end
    end
  end

  // stimulus
  initial begin
    mode_t             m;
    logic [NODE_W-1:0] n;
    logic [GROUP_W-1:0] g;
    member_result_t    want;
    int                r;
    mismatch_count = 0;
    for (int gi = 0; gi < NUM_GROUPS; gi++)
      for (int s = 0; s < SLOTS_PER_GROUP; s++)
        member_rows[gi][s] = '0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_mode     <= MODE_INSERT;
    in_node_id  <= '0;
    in_group_id <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (directed_rows[i]) begin
      want = '0;
      want.status       = directed_rows[i].w_status;
      want.present      = directed_rows[i].w_present;
      want.can_add      = directed_rows[i].w_can_add;
      want.member_valid = directed_rows[i].w_member_valid;
      want.last         = directed_rows[i].w_last;
      send_request(directed_rows[i].mode, directed_rows[i].node, directed_rows[i].group,
                   directed_rows[i].typed, want);
    end

    // random requests: small node pool and mostly valid groups so rows fill up
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(99, 0);
      if (r < 45)      m = MODE_INSERT;
      else if (r < 70) m = MODE_LOOKUP;
      else if (r < 99) m = MODE_LIST;
      else             m = MODE_CLEAR;
      r = $urandom_range(99, 0);
      if (r < 75)      n = NODE_W'($urandom_range(12, 1));
      else if (r < 80) n = '0;
      else             n = NODE_W'($urandom_range(255, 0));
      r = $urandom_range(99, 0);
      if (r < 40)      g = GROUP_W'($urandom_range(2, 1));
      else if (r < 85) g = GROUP_W'($urandom_range(NUM_GROUPS, 3));
      else if (r < 92) g = '0;
      else             g = GROUP_W'($urandom_range(255, NUM_GROUPS + 1));
      send_request(m, n, g, PREDICTED, '0);
    end
    start <= 1'b0;

    // drain, then a few quiet cycles to catch stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> group_membership_table_core.f
+incdir+hdl
hdl/gmt_pkg.sv
hdl/group_membership_table_core.sv
dv/tb_top.sv
